// File: sv/settling_weight_averager_top_defines.svh
// Assertion macros used by the averager top module.
// Each macro expects clk and arst_n to be in scope where it is used.
`ifndef SETTLING_WEIGHT_AVERAGER_TOP_DEFINES_SVH
`define SETTLING_WEIGHT_AVERAGER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/swa_pkg.sv
package swa_pkg;

	// Register indexes of the configuration port.
	localparam logic [7:0] REG_SIGMA     = 8'd0;
	localparam logic [7:0] REG_AVG_LIMIT = 8'd1;

	// Field widths fixed by the interface.
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int SIGMA_W    = 16;
	localparam int COUNT_W    = 8;
	localparam int AVG_W      = 24;
	localparam int GRAMS_W    = 16;
	localparam int TENTH_W    = 4;
	localparam int OUT_DATA_W = 48;

	// Divisor of the shared divider: count + 1 or the limit, at most 255.
	localparam int DEN_W = COUNT_W + 1;

	// Step threshold is five times sigma.
	localparam int THR_MULT = 5;
	localparam int THR_W    = SIGMA_W + 3;

	// Reset values of the registers.
	localparam logic [SIGMA_W-1:0] SIGMA_RESET     = 16'd26;
	localparam logic [COUNT_W-1:0] AVG_LIMIT_RESET = 8'd10;

	// Fixed point: 256 counts per gram, display in tenths.
	localparam int FRAC_BITS    = 8;
	localparam int TENTHS       = 10;
	localparam int ONE_GRAM     = 256;
	// Smallest magnitude whose value in tenths truncates to a nonzero value.
	localparam int NEG_MIN_MAG  = (ONE_GRAM + TENTHS - 1) / TENTHS;

	// Status of the shared divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Display split of the average.
	typedef struct packed {
		logic               negative;
		logic [GRAMS_W-1:0] whole_grams;
		logic [TENTH_W-1:0] tenth_digit;
	} disp_t;

endpackage

// File: sv/swa_divider.sv
module swa_divider import swa_pkg::*; #(
	parameter int NUM_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic [NUM_W-1:0] quotient,
	output div_stat_t        stat
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] dvd_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial_c;
	logic             ge_c;

	// One restoring step: shift in the next dividend bit and try to subtract.
	always_comb begin
		trial_c = {rem_q, dvd_q[NUM_W-1]};
		ge_c    = trial_c >= {1'b0, den_q};
	end

	// Step counter and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: quotient bits replace the dividend bits as they shift out.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[NUM_W-2:0], ge_c};
			rem_q <= ge_c ? DEN_W'(trial_c - {1'b0, den_q}) : trial_c[DEN_W-1:0];
		end
	end

	assign quotient  = dvd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: sv/swa_display.sv
module swa_display import swa_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic signed [SAMPLE_BITS-1:0] avg,
	output disp_t                         disp
);

	logic [SAMPLE_BITS-1:0]           mag_c;
	logic [FRAC_BITS+3:0]             frac10_c;
	logic [GRAMS_W+SAMPLE_BITS-FRAC_BITS-1:0] whole_c;

	// Split the magnitude into whole grams and the truncated tenth digit.
	// The tenth digit depends only on the fraction bits: 10 * frac / 256.
	always_comb begin
		mag_c    = avg[SAMPLE_BITS-1] ? SAMPLE_BITS'(-avg) : avg;
		frac10_c = {3'b000, mag_c[FRAC_BITS-1:0], 1'b0}
		         + {1'b0, mag_c[FRAC_BITS-1:0], 3'b000};
		whole_c  = {{GRAMS_W{1'b0}}, mag_c[SAMPLE_BITS-1:FRAC_BITS]};

		disp.whole_grams = whole_c[GRAMS_W-1:0];
		disp.tenth_digit = frac10_c[FRAC_BITS+3:FRAC_BITS];
		disp.negative    = avg[SAMPLE_BITS-1] && (mag_c >= SAMPLE_BITS'(NEG_MIN_MAG));
	end

endmodule

// File: sv/settling_weight_averager_top.sv
// Settling weight averager. Each request on the sample stream carries one weight
// sample (1/256 g, two's complement) and a restart flag, and yields exactly one
// result with the updated average, a settled flag and the display split. A jump
// larger than five times sigma from the previous sample, or restart, starts the
// average over. Below avg_limit samples the average is the growing mean, after
// that an exponential average with weight 1/avg_limit (avg_limit 0 acts as 1).
// An item that needs a division passes through the check, load, divide, finish
// and output states, and in the divide state the bit-serial divider takes one
// quotient bit per cycle; an item that starts the average over skips the divider
// and goes from check straight to output. The result waits in an output
// register, so a new sample is taken while the previous result is not yet read.
`include "settling_weight_averager_top_defines.svh"

module settling_weight_averager_top import swa_pkg::*; #(
	parameter int SAMPLE_BITS = 24,
	localparam int IN_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write channel.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Sample stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // sample, zero padding
	input  logic                  s_tuser,   // restart
	// Result stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // average, negative, whole_grams,
	                                         // tenth_digit, zero padding
	output logic                  m_tuser    // settled
);

	localparam int NUM_W = SAMPLE_BITS + 9;
	localparam int DVD_W = SAMPLE_BITS + 8;
	localparam int CMP_W = (SAMPLE_BITS + 1 > THR_W) ? SAMPLE_BITS + 1 : THR_W;
	localparam int PAD_W = OUT_DATA_W - AVG_W - 1 - GRAMS_W - TENTH_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LOAD,
		ST_DIV,
		ST_FINISH,
		ST_OUT
	} state_t;

	state_t                        state_q;
	logic [SIGMA_W-1:0]            sigma_q;
	logic [COUNT_W-1:0]            avg_limit_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          restart_q;
	logic signed [SAMPLE_BITS-1:0] prev_q;
	logic signed [SAMPLE_BITS-1:0] ra_q;
	logic [COUNT_W-1:0]            count_q;
	logic signed [NUM_W-1:0]       prod_q;
	logic [DEN_W-1:0]              den_q;
	logic                          ema_q;
	logic                          neg_q;
	logic                          m_tvalid_q;
	logic [OUT_DATA_W-1:0]         m_tdata_q;
	logic                          m_tuser_q;

	logic signed [SAMPLE_BITS:0]   diff_c;
	logic [SAMPLE_BITS:0]          absdiff_c;
	logic [THR_W-1:0]              thr_c;
	logic                          start_over_c;
	logic [COUNT_W-1:0]            lim_c;
	logic [COUNT_W-1:0]            count_eff_c;
	logic signed [NUM_W-1:0]       prod_c;
	logic signed [NUM_W-1:0]       num_c;
	logic signed [NUM_W-1:0]       num_mag_c;
	logic signed [NUM_W-1:0]       quot_s_c;
	logic [DVD_W-1:0]              quot;
	logic                          div_start;
	div_stat_t                     div_stat;
	disp_t                         disp;
	logic signed [AVG_W+SAMPLE_BITS-1:0] avg_ext_c;

	// Step detection and branch selection for the sample being processed.
	always_comb begin
		diff_c       = {sample_q[SAMPLE_BITS-1], sample_q} - {prev_q[SAMPLE_BITS-1], prev_q};
		absdiff_c    = diff_c[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff_c) : diff_c;
		thr_c        = THR_W'({sigma_q, 2'b00}) + THR_W'(sigma_q);
		start_over_c = restart_q || (CMP_W'(absdiff_c) > CMP_W'(thr_c));
		lim_c        = (avg_limit_q == '0) ? COUNT_W'(1) : avg_limit_q;
		count_eff_c  = start_over_c ? '0 : count_q;
		prod_c       = NUM_W'(ra_q) * NUM_W'($signed({1'b0, count_eff_c}));
	end

	// Numerator of the division and the signed quotient.
	always_comb begin
		num_c     = prod_q + NUM_W'(sample_q);
		num_mag_c = num_c[NUM_W-1] ? -num_c : num_c;
		quot_s_c  = neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
		div_start = (state_q == ST_LOAD);
	end

	swa_divider #(
		.NUM_W(DVD_W)
	) u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(num_mag_c[DVD_W-1:0]),
		.divisor (den_q),
		.quotient(quot),
		.stat    (div_stat)
	);

	swa_display #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_display (
		.avg (ra_q),
		.disp(disp)
	);

	assign avg_ext_c = (AVG_W+SAMPLE_BITS)'(ra_q);

	// Configuration registers; writes beyond the register list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q     <= SIGMA_RESET;
			avg_limit_q <= AVG_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SIGMA:     sigma_q     <= cfg_data;
				REG_AVG_LIMIT: avg_limit_q <= cfg_data[COUNT_W-1:0];
				default:       ;
			endcase
		end
	end

	// Sequencer with averaging state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			prev_q     <= '0;
			ra_q       <= '0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// A result read by the sink frees the output register unless a new
			// one is loaded in its place.
			if (m_tvalid_q && m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					prev_q <= sample_q;
					if (count_eff_c == '0) begin
						ra_q    <= sample_q;
						count_q <= COUNT_W'(1);
						state_q <= ST_OUT;
					end else if (count_eff_c < lim_c) begin
						count_q <= count_eff_c + COUNT_W'(1);
						state_q <= ST_LOAD;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (ema_q) begin
						ra_q <= ra_q + quot_s_c[SAMPLE_BITS-1:0];
					end else begin
						ra_q <= quot_s_c[SAMPLE_BITS-1:0];
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers of the sequencer.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			sample_q  <= s_tdata[SAMPLE_BITS-1:0];
			restart_q <= s_tuser;
		end
		if (state_q == ST_CHECK) begin
			ema_q <= (count_eff_c >= lim_c);
			if (count_eff_c < lim_c) begin
				prod_q <= prod_c;
				den_q  <= {1'b0, count_eff_c} + DEN_W'(1);
			end else begin
				prod_q <= -NUM_W'(ra_q);
				den_q  <= {1'b0, lim_c};
			end
		end
		if (state_q == ST_LOAD) begin
			neg_q <= num_c[NUM_W-1];
		end
		if (state_q == ST_OUT && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {{PAD_W{1'b0}}, disp.tenth_digit, disp.whole_grams,
			              disp.negative, avg_ext_c[AVG_W-1:0]};
			m_tuser_q <= (count_q >= lim_c);
		end
	end

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	`SWA_ASSERT_SAME(a_no_accept_while_dividing, div_stat.busy, !s_tready,
		"sample accepted during division")
	`SWA_ASSERT_SAME(a_div_done_in_div, div_stat.done, state_q == ST_DIV,
		"divider finished outside the divide state")
	`SWA_ASSERT_NEXT(a_count_nonzero, state_q == ST_CHECK, count_q != '0,
		"averaged count is zero after an update")

endmodule
